/* hdl/ltu_pkg.sv */
// Shared types, constants and encode functions for the legacy text to UTF-8 transcoder.
`default_nettype none
package ltu_pkg;

	localparam int RUN_MAX    = 3;
	localparam int RUN_LEN_W  = $clog2(RUN_MAX + 1);
	localparam int RUN_IDX_W  = $clog2(RUN_MAX);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [15:0] BOM_UNIT   = 16'hFEFF;
	localparam logic [15:0] LIM_1BYTE  = 16'h0080;
	localparam logic [15:0] LIM_2BYTE  = 16'h0800;
	localparam logic [7:0]  LEAD2_MARK = 8'hC0;
	localparam logic [7:0]  LEAD3_MARK = 8'hE0;
	localparam logic [7:0]  CONT_MARK  = 8'h80;
	localparam logic [5:0]  CONT_MASK  = 6'h3F;

	typedef enum logic [1:0] {
		MODE_PASS = 2'd0,
		MODE_U16  = 2'd1,
		MODE_1252 = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	// one queued run: the UTF-8 bytes caused by one input item
	typedef struct packed {
		logic [RUN_LEN_W-1:0]         len;
		logic [RUN_MAX-1:0][7:0]      bytes;
	} run_t;

	typedef struct packed {
		logic valid;
		run_t run;
	} push_t;

	function automatic logic [15:0] cp1252_unit(input logic [7:0] b);
		logic [15:0] u;
		u = {8'h00, b};
		if (b inside {[8'h80:8'h9F]}) begin
			case (b[4:0])
				5'h00: u = 16'h20AC;
				5'h01: u = 16'h0081;
				5'h02: u = 16'h201A;
				5'h03: u = 16'h0192;
				5'h04: u = 16'h201E;
				5'h05: u = 16'h2026;
				5'h06: u = 16'h2020;
				5'h07: u = 16'h2021;
				5'h08: u = 16'h02C6;
				5'h09: u = 16'h2030;
				5'h0A: u = 16'h0160;
				5'h0B: u = 16'h2039;
				5'h0C: u = 16'h0152;
				5'h0D: u = 16'h008D;
				5'h0E: u = 16'h017D;
				5'h0F: u = 16'h008F;
				5'h10: u = 16'h0090;
				5'h11: u = 16'h2018;
				5'h12: u = 16'h2019;
				5'h13: u = 16'h201C;
				5'h14: u = 16'h201D;
				5'h15: u = 16'h2022;
				5'h16: u = 16'h2013;
				5'h17: u = 16'h2014;
				5'h18: u = 16'h02DC;
				5'h19: u = 16'h2122;
				5'h1A: u = 16'h0161;
				5'h1B: u = 16'h203A;
				5'h1C: u = 16'h0153;
				5'h1D: u = 16'h009D;
				5'h1E: u = 16'h017E;
				5'h1F: u = 16'h0178;
				default: u = {8'h00, b};
			endcase
		end
		return u;
	endfunction

	function automatic push_t encode_unit(input logic [15:0] u);
		push_t p;
		p = '0;
		if (u == 16'h0000) begin
			p.valid = 1'b0;
		end else if (u < LIM_1BYTE) begin
			p.valid        = 1'b1;
			p.run.len      = RUN_LEN_W'(1);
			p.run.bytes[0] = u[7:0];
		end else if (u < LIM_2BYTE) begin
			p.valid        = 1'b1;
			p.run.len      = RUN_LEN_W'(2);
			p.run.bytes[0] = LEAD2_MARK | {3'b000, u[10:6]};
			p.run.bytes[1] = CONT_MARK | {2'b00, u[5:0] & CONT_MASK};
		end else begin
			p.valid        = 1'b1;
			p.run.len      = RUN_LEN_W'(3);
			p.run.bytes[0] = LEAD3_MARK | {4'h0, u[15:12]};
			p.run.bytes[1] = CONT_MARK | {2'b00, u[11:6] & CONT_MASK};
			p.run.bytes[2] = CONT_MARK | {2'b00, u[5:0] & CONT_MASK};
		end
		return p;
	endfunction

endpackage
`default_nettype wire

/* hdl/ltu_front.sv */
// Front end: mode register, UTF-16 pairing state and conversion of one byte into a run.
`default_nettype none
module ltu_front
	import ltu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [1:0] cfg_wr_data,
	input  wire logic       accept,
	input  wire logic [7:0] in_byte,
	input  wire logic       start_of_text,
	output push_t           push
);

	mode_t       mode_q;
	logic [7:0]  held_low_byte_q;
	logic        low_byte_pending_q;
	logic        first_unit_of_text_q;

	logic [7:0]  held_eff;
	logic        pend_eff;
	logic        first_eff;
	logic [15:0] unit;
	logic [7:0]  held_nxt;
	logic        pend_nxt;
	logic        first_nxt;

	assign held_eff  = start_of_text ? 8'h00 : held_low_byte_q;
	assign pend_eff  = start_of_text ? 1'b0 : low_byte_pending_q;
	assign first_eff = start_of_text ? 1'b1 : first_unit_of_text_q;
	assign unit      = {in_byte, held_eff};

	always_comb begin
		push      = '0;
		held_nxt  = held_eff;
		pend_nxt  = pend_eff;
		first_nxt = first_eff;
		case (mode_q)
			MODE_PASS: begin
				push.valid        = 1'b1;
				push.run.len      = RUN_LEN_W'(1);
				push.run.bytes[0] = in_byte;
			end
			MODE_U16: begin
				if (!pend_eff) begin
					held_nxt = in_byte;
					pend_nxt = 1'b1;
				end else begin
					pend_nxt  = 1'b0;
					first_nxt = 1'b0;
					// drop a leading byte order mark
					if (!(first_eff && unit == BOM_UNIT)) begin
						push = encode_unit(unit);
					end
				end
			end
			MODE_1252: begin
				push = encode_unit(cp1252_unit(in_byte));
			end
			default: begin
				push = '0;
			end
		endcase
		if (!accept) begin
			push.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q               <= MODE_PASS;
			held_low_byte_q      <= 8'h00;
			low_byte_pending_q   <= 1'b0;
			first_unit_of_text_q <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= mode_t'(cfg_wr_data);
			end
			if (accept) begin
				held_low_byte_q      <= held_nxt;
				low_byte_pending_q   <= pend_nxt;
				first_unit_of_text_q <= first_nxt;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/ltu_queue.sv */
// Short run queue between the front end and the byte serializer.
`default_nettype none
module ltu_queue
	import ltu_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       full,
	output logic       head_valid,
	output run_t       head,
	input  wire logic  pop
);

	run_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/ltu_back.sv */
// Back end: serializes queued runs into UTF-8 bytes through an output register.
`default_nettype none
module ltu_back
	import ltu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       head_valid,
	input  wire run_t       head,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            last_of_run
);

	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 last_q;
	logic [RUN_IDX_W-1:0] idx_q;
	logic                 take;
	logic                 is_last;
	logic [7:0]           cur_byte;

	assign take    = !out_valid_q || out_ready;
	assign is_last = (idx_q == RUN_IDX_W'(head.len - RUN_LEN_W'(1)));
	assign pop     = take && head_valid && is_last;

	always_comb begin
		case (idx_q)
			RUN_IDX_W'(0): cur_byte = head.bytes[0];
			RUN_IDX_W'(1): cur_byte = head.bytes[1];
			RUN_IDX_W'(2): cur_byte = head.bytes[2];
			default:       cur_byte = head.bytes[0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (take && head_valid) begin
			out_byte_q <= cur_byte;
			last_q     <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (take) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= is_last ? '0 : idx_q + RUN_IDX_W'(1);
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

endmodule
`default_nettype wire

/* hdl/legacy_text_to_utf8_transcoder.sv */
// Top level of the legacy text to UTF-8 transcoder.
//
// channel   signals                                   handshake
// input     in_byte, start_of_text                    in_valid / in_ready
// output    out_byte, last_of_run                     out_valid / out_ready
// config    cfg_wr_data (source_mode)                 cfg_wr_en, no wait
//
// An input item is converted in the cycle it is accepted and queued as a run
// of 0 to 3 bytes; the serializer sends one byte per cycle while out_ready is
// high, so the sustained item rate is set by the run length on the output port.
// The first byte of a run passes the run queue and the output register on its way out.
// in_ready drops only while the two-entry run queue is full.
// Reset clears the mode to passthrough, the pairing state and the queue.
`default_nettype none
module legacy_text_to_utf8_transcoder
	import ltu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [1:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       start_of_text,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            last_of_run
);

	push_t push;
	logic  full;
	logic  head_valid;
	run_t  head;
	logic  pop;

	assign in_ready = !full;

	ltu_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.accept        (in_valid && in_ready),
		.in_byte       (in_byte),
		.start_of_text (start_of_text),
		.push          (push)
	);

	ltu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	ltu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the legacy text to UTF-8 transcoder: directed and random text.
module testbench
	import ltu_pkg::*;
();

	localparam logic [15:0] CP1252_HIGH [32] = '{
		16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
		16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
		16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
		16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
	};

	typedef struct {
		logic [7:0] value;
		logic       last;
	} utf8_byte_t;

	class transcode_tracker;
		mode_t      mode;
		logic [7:0] held_low;
		logic       low_pending;
		logic       first_unit;
		utf8_byte_t utf8_due[$];
		int         errors;

		function new();
			mode        = MODE_PASS;
			held_low    = 8'h00;
			low_pending = 1'b0;
			first_unit  = 1'b1;
			errors      = 0;
		endfunction

		function void emit(input logic [7:0] v, input logic last);
			utf8_byte_t e;
			e.value = v;
			e.last  = last;
			utf8_due.insert(utf8_due.size(), e);
		endfunction

		function void encode(input logic [15:0] u);
			if (u == 16'h0000) begin
				return;
			end
			if (u < 16'h0080) begin
				emit(u[7:0], 1'b1);
			end else if (u < 16'h0800) begin
				emit(8'hC0 | {3'b000, u[10:6]}, 1'b0);
				emit(8'h80 | {2'b00, u[5:0]}, 1'b1);
			end else begin
				emit(8'hE0 | {4'h0, u[15:12]}, 1'b0);
				emit(8'h80 | {2'b00, u[11:6]}, 1'b0);
				emit(8'h80 | {2'b00, u[5:0]}, 1'b1);
			end
		endfunction

		function void note_input(input logic [7:0] b, input logic sot);
			logic [15:0] unit;
			logic        was_first;
			if (sot) begin
				low_pending = 1'b0;
				held_low    = 8'h00;
				first_unit  = 1'b1;
			end
			case (mode)
				MODE_PASS: begin
					emit(b, 1'b1);
				end
				MODE_U16: begin
					if (!low_pending) begin
						held_low    = b;
						low_pending = 1'b1;
					end else begin
						unit        = {b, held_low};
						low_pending = 1'b0;
						was_first   = first_unit;
						first_unit  = 1'b0;
						if (!(was_first && unit == BOM_UNIT)) begin
							encode(unit);
						end
					end
				end
				MODE_1252: begin
					if (b >= 8'h80 && b <= 8'h9F) begin
						unit = CP1252_HIGH[b[4:0]];
					end else begin
						unit = {8'h00, b};
					end
					encode(unit);
				end
				default: begin
				end
			endcase
		endfunction

		function void check_output(input logic [7:0] v, input logic last);
			utf8_byte_t due;
			if (utf8_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected output byte %02h last_of_run %0b", $time, v, last);
				return;
			end
			due = utf8_due.pop_front();
			if (v !== due.value) begin
				errors++;
				$display("%0t: out_byte expected %02h actual %02h", $time, due.value, v);
			end
			if (last !== due.last) begin
				errors++;
				$display("%0t: last_of_run expected %0b actual %0b", $time, due.last, last);
			end
		endfunction
	endclass

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       cfg_wr_en     = 1'b0;
	logic [1:0] cfg_wr_data   = 2'd0;
	logic       in_valid      = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte       = 8'h00;
	logic       start_of_text = 1'b0;
	logic       out_valid;
	logic       out_ready     = 1'b0;
	logic [7:0] out_byte;
	logic       last_of_run;

	int               tx_idle_pct   = 0;
	int               rx_stall_pct  = 0;
	bit               long_hold_req = 1'b0;
	transcode_tracker tracker;

	legacy_text_to_utf8_transcoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.start_of_text(start_of_text),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("end of test: mismatches");
		$finish;
	end

	// receiver: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (80) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			tracker.check_output(out_byte, last_of_run);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic sot);
		bit taken;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		in_byte       <= b;
		start_of_text <= sot;
		do begin
			@(negedge clk);
			taken = in_valid && in_ready;
			if (taken) begin
				tracker.note_input(b, sot);
			end
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tracker.utf8_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(input mode_t m);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		tracker.mode = m;
	endtask

	function automatic logic [15:0] random_unit();
		case ($urandom_range(7))
			0:       return 16'($urandom_range(16'h0001, 16'h007F));
			1:       return 16'($urandom_range(16'h0080, 16'h07FF));
			2:       return 16'($urandom_range(16'h0800, 16'hFFFF));
			3:       return 16'h0000;
			4:       return BOM_UNIT;
			5:       return 16'($urandom_range(16'hD800, 16'hDFFF));
			default: return 16'($urandom());
		endcase
	endfunction

	// one text in the current mode; in UTF-16 mode mostly whole units, some stray bytes
	task automatic send_text(input int budget);
		logic [15:0] unit;
		logic [7:0]  b;
		logic        sot;
		int          sent;
		sent = 0;
		sot  = 1'b1;
		if (tracker.mode == MODE_U16 && $urandom_range(1) == 1) begin
			send_item(8'hFF, 1'b1);
			send_item(8'hFE, 1'b0);
			sent = 2;
			sot  = 1'b0;
		end
		while (sent < budget) begin
			if (tracker.mode == MODE_U16 && $urandom_range(15) != 0) begin
				unit = random_unit();
				send_item(unit[7:0], sot);
				send_item(unit[15:8], 1'b0);
				sent += 2;
			end else begin
				if ($urandom_range(2) == 0) begin
					b = 8'($urandom_range(8'h80, 8'h9F));
				end else begin
					b = 8'($urandom());
				end
				send_item(b, sot | ($urandom_range(15) == 0));
				sent++;
			end
			sot = 1'b0;
		end
	endtask

	initial begin
		int    r;
		int    seg;
		int    phase_sent;
		mode_t m;
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_mode(MODE_PASS);
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b0);

		write_mode(MODE_U16);
		send_item(8'hFF, 1'b1);
		send_item(8'hFE, 1'b0);
		send_item(8'h41, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFE, 1'b0);
		send_item(8'hAC, 1'b0);
		send_item(8'h20, 1'b0);
		send_item(8'h3D, 1'b0);
		send_item(8'hD8, 1'b0);
		send_item(8'h7F, 1'b1);
		send_item(8'hE9, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'hFE, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'h34, 1'b1);

		// hold the low byte across a mode change
		write_mode(MODE_1252);
		send_item(8'h80, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h9F, 1'b0);
		write_mode(MODE_U16);
		send_item(8'h12, 1'b0);
		send_item(8'h77, 1'b0);

		// drop the byte, but still clear pairing
		write_mode(MODE_NONE);
		send_item(8'hAA, 1'b1);
		write_mode(MODE_U16);
		send_item(8'h41, 1'b0);
		send_item(8'h00, 1'b0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct  = 48;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 48;
				end
				default: begin
					tx_idle_pct  = 24;
					rx_stall_pct = 24;
				end
			endcase
			phase_sent = 0;
			if (ph == 0) begin
				write_mode(MODE_1252);
				long_hold_req = 1'b1;
				send_text(24);
				phase_sent = 24;
			end
			while (phase_sent < 40) begin
				r = $urandom_range(15);
				if (r == 0) begin
					m = MODE_NONE;
				end else if (r < 4) begin
					m = MODE_PASS;
				end else if (r < 11) begin
					m = MODE_U16;
				end else begin
					m = MODE_1252;
				end
				if (m != tracker.mode) begin
					write_mode(m);
				end
				seg = (m == MODE_NONE) ? 4 : $urandom_range(6, 16);
				send_text(seg);
				if (m != MODE_NONE) begin
					phase_sent += seg;
				end
			end
		end

		wait_drained();
		if (tracker.errors == 0 && tracker.utf8_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
